>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expression holds at every edge
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/cht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// Shared widths, codes, controller states and control structs of the hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    // field widths
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 5;

    // bucket count after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

    // remainder unit: quotient bits resolved per cycle
    localparam int DIV_BITS_PER_CYCLE = 4;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_ALLOC,
        S_WALK,
        S_CMP,
        S_RELEASE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;        // capture item, start remainder
        logic load_walk;    // cur = bucket head, prev = empty
        logic rd_cur;       // read node memories at cur
        logic rd_free;      // read link at free list head
        logic alloc_free;   // insert using the free list head node
        logic alloc_fresh;  // insert using the next unused node
        logic advance;      // step along the chain
        logic unlink_prev;  // bypass the matched node
        logic release_node; // push matched node onto the free list
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              div_done;
        logic              free_avail;
        logic              fresh_avail;
        logic              cur_end;
        logic              match;
        logic [FUNC_W-1:0] func;
    } sts_t;

endpackage

>>> sv/cht_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_div
// Restoring remainder unit: key modulo bucket count, a few bits per cycle.
// ----------------------------------------------------------------------------
module cht_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cht_pkg::KEY_W-1:0] dividend,
    input  logic [cht_pkg::CFG_W-1:0] divisor,
    output logic                      done,
    output logic [cht_pkg::CFG_W-1:0] rem
);
    import cht_pkg::*;

    localparam int STEPS = (KEY_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int PAD_W = STEPS * DIV_BITS_PER_CYCLE;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [PAD_W-1:0] num_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [CFG_W-1:0] rem_next;

    // one group of shift-and-subtract steps
    always_comb
    begin
        logic [CFG_W:0] r;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            r = {rem_next, num_reg[PAD_W-1-i]};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
            rem_next = r[CFG_W-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= PAD_W'(dividend);
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            num_reg <= num_reg << DIV_BITS_PER_CYCLE;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/cht_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cht_datapath
// Bucket heads, free list, node pool memories and the bucket remainder unit.
// ----------------------------------------------------------------------------
module cht_datapath #(
    parameter int NUM_BUCKETS = 16,
    parameter int POOL_NODES  = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cht_pkg::CFG_W-1:0]     cfg_data,
    input  logic [cht_pkg::FUNC_W-1:0]    func,
    input  logic [cht_pkg::KEY_W-1:0]     key,
    input  logic [cht_pkg::VALUE_W-1:0]   value,
    input  cht_pkg::cmd_t                 cmd,
    output cht_pkg::sts_t                 sts
);
    import cht_pkg::*;

    // the 5-bit bucket count caps the heads ever addressed
    localparam int CFG_MAX    = (1 << CFG_W) - 1;
    localparam int HEAD_DEPTH = (NUM_BUCKETS < CFG_MAX) ? NUM_BUCKETS : CFG_MAX;
    localparam int BKT_W      = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
    localparam logic [CFG_W-1:0] BC_CAP = CFG_W'(HEAD_DEPTH);
    localparam logic [CFG_W-1:0] BC_ONE = CFG_W'(1);
    localparam int PTR_W  = $clog2(POOL_NODES + 1);
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam logic [PTR_W-1:0] EMPTY = PTR_W'(POOL_NODES);

    logic [CFG_W-1:0]   bc_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [PTR_W-1:0]   head_reg [HEAD_DEPTH];
    logic [PTR_W-1:0]   free_head_reg;
    logic [PTR_W-1:0]   fresh_reg;
    logic [PTR_W-1:0]   cur_reg;
    logic [PTR_W-1:0]   prev_reg;
    logic [VALUE_W-1:0] val_rdata_reg;
    logic [PTR_W-1:0]   link_rdata_reg;

    logic [VALUE_W-1:0] value_mem [POOL_NODES];
    logic [PTR_W-1:0]   link_mem  [POOL_NODES];

    logic [CFG_W-1:0]  bc_eff;
    logic              div_done;
    logic [CFG_W-1:0]  div_rem;
    logic [BKT_W-1:0]  bucket;
    logic [PTR_W-1:0]  head_rd;
    logic              alloc;
    logic [PTR_W-1:0]  alloc_node;
    logic              prev_empty;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [PTR_W-1:0]  link_wdata;
    logic [NODE_W-1:0] link_raddr;

    // effective bucket count: zero is one, saturate at the head count
    always_comb
    begin
        if (bc_reg == '0)
        begin
            bc_eff = BC_ONE;
        end
        else if (bc_reg > BC_CAP)
        begin
            bc_eff = BC_CAP;
        end
        else
        begin
            bc_eff = bc_reg;
        end
    end

    cht_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.latch),
        .dividend (key),
        .divisor  (bc_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign bucket     = div_rem[BKT_W-1:0];
    assign head_rd    = head_reg[bucket];
    assign alloc      = cmd.alloc_free | cmd.alloc_fresh;
    assign alloc_node = cmd.alloc_free ? free_head_reg : fresh_reg;
    assign prev_empty = (prev_reg >= EMPTY);

    // link memory write port select
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = alloc_node[NODE_W-1:0];
        link_wdata = head_rd;
        if (alloc)
        begin
            link_we = 1'b1;
        end
        else if (cmd.unlink_prev && !prev_empty)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg[NODE_W-1:0];
            link_wdata = link_rdata_reg;
        end
        else if (cmd.release_node)
        begin
            link_we    = 1'b1;
            link_waddr = cur_reg[NODE_W-1:0];
            link_wdata = free_head_reg;
        end
    end

    assign link_raddr = cmd.rd_free ? free_head_reg[NODE_W-1:0] : cur_reg[NODE_W-1:0];

    // table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg        <= CFG_RESET;
            func_reg      <= FN_INSERT;
            free_head_reg <= EMPTY;
            fresh_reg     <= '0;
            cur_reg       <= EMPTY;
            prev_reg      <= EMPTY;
            for (int i = 0; i < HEAD_DEPTH; i++)
            begin
                head_reg[i] <= EMPTY;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                bc_reg <= cfg_data;
            end
            if (cmd.latch)
            begin
                func_reg <= func;
            end
            // allocation and bucket head update
            if (alloc)
            begin
                head_reg[bucket] <= alloc_node;
            end
            else if (cmd.unlink_prev && prev_empty)
            begin
                head_reg[bucket] <= link_rdata_reg;
            end
            if (cmd.alloc_free)
            begin
                free_head_reg <= link_rdata_reg;
            end
            else if (cmd.release_node)
            begin
                free_head_reg <= cur_reg;
            end
            if (cmd.alloc_fresh)
            begin
                fresh_reg <= fresh_reg + 1'b1;
            end
            // chain walk pointers
            if (cmd.load_walk)
            begin
                cur_reg  <= head_rd;
                prev_reg <= EMPTY;
            end
            else if (cmd.advance)
            begin
                cur_reg  <= link_rdata_reg;
                prev_reg <= cur_reg;
            end
        end
    end

    // item value
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            val_reg <= value;
        end
    end

    // node pool memories, registered reads
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            value_mem[alloc_node[NODE_W-1:0]] <= val_reg;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.rd_cur)
        begin
            val_rdata_reg <= value_mem[cur_reg[NODE_W-1:0]];
        end
        if (cmd.rd_cur || cmd.rd_free)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    always_comb
    begin
        sts.div_done    = div_done;
        sts.free_avail  = (free_head_reg < EMPTY);
        sts.fresh_avail = (fresh_reg < EMPTY);
        sts.cur_end     = (cur_reg >= EMPTY);
        sts.match       = (val_rdata_reg == val_reg);
        sts.func        = func_reg;
    end

    // checks
    `ASSERT_IMPLIES(a_read_inside_pool, cmd.rd_cur, cur_reg < EMPTY)
    `ASSERT_IMPLIES(a_fresh_not_past_pool, cmd.alloc_fresh, fresh_reg < EMPTY)
    `ASSERT_NEXT(a_release_pushes_cur, cmd.release_node, free_head_reg == $past(cur_reg))

endmodule

>>> sv/cht_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cht_ctrl
// Operation sequencer: remainder wait, insert, chain walk, unlink, result strobe.
// ----------------------------------------------------------------------------
module cht_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  cht_pkg::sts_t                 sts,
    output cht_pkg::cmd_t                 cmd,
    output logic                          busy,
    output logic                          done,
    output logic [cht_pkg::STATUS_W-1:0]  status
);
    import cht_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                post;
    logic [STATUS_W-1:0] post_code;
    logic [3:0]          pool_wr;

    // state register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_NOT_FOUND;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= post;
            if (post)
            begin
                status_reg <= post_code;
            end
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        post       = 1'b0;
        post_code  = ST_NOT_FOUND;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                case (sts.func)
                    FN_INSERT:
                    begin
                        if (sts.free_avail)
                        begin
                            cmd.rd_free = 1'b1;
                            state_next  = S_ALLOC;
                        end
                        else if (sts.fresh_avail)
                        begin
                            cmd.alloc_fresh = 1'b1;
                            post            = 1'b1;
                            post_code       = ST_INSERTED;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            post       = 1'b1;
                            post_code  = ST_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    FN_SEARCH, FN_REMOVE:
                    begin
                        cmd.load_walk = 1'b1;
                        state_next    = S_WALK;
                    end
                    default:
                    begin
                        post       = 1'b1;
                        post_code  = ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ALLOC:
            begin
                cmd.alloc_free = 1'b1;
                post           = 1'b1;
                post_code      = ST_INSERTED;
                state_next     = S_IDLE;
            end
            S_WALK:
            begin
                if (sts.cur_end)
                begin
                    post       = 1'b1;
                    post_code  = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!sts.match)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_WALK;
                end
                else if (sts.func == FN_SEARCH)
                begin
                    post       = 1'b1;
                    post_code  = ST_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.unlink_prev = 1'b1;
                    state_next      = S_RELEASE;
                end
            end
            S_RELEASE:
            begin
                cmd.release_node = 1'b1;
                post             = 1'b1;
                post_code        = ST_REMOVED;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign pool_wr = {cmd.alloc_free, cmd.alloc_fresh, cmd.unlink_prev, cmd.release_node};

    // checks
    `ASSERT_NEXT(a_start_enters_div, start && !busy, state_reg == S_DIV)
    `ASSERT_IMPLIES(a_done_follows_work, done_reg, $past(state_reg) != S_IDLE)
    `ASSERT_ALWAYS(a_one_pool_write, $onehot0(pool_wr))

endmodule

>>> sv/chained_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table
// Separate chaining hash table over a fixed node pool, with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (func, key, value) is taken at a clock edge with
//   start high and busy low. busy stays high until the item's result is out.
//   Result channel: done is high for one cycle with status; the receiver must
//   take it then, it cannot stall the block. A new item may be started in the
//   same cycle as done.
//   Config channel: cfg_data (bucket count) is written when cfg_valid and
//   cfg_ready are both high; cfg_ready is always high. Write only when idle.
// Sequence of an item:
//   The bucket is key modulo the bucket count, resolved 4 bits a cycle by
//   the remainder unit; its done flag is registered, the controller then
//   acts on the bucket head. Insert, pool full and unknown operation post
//   at the bucket head (a free list node adds a state that reads its link).
//   Search / remove: each node compared passes a walk and a compare state;
//   a remove hit adds a state that pushes the node onto the free list; a
//   miss or an empty bucket posts when the walk reaches the chain end.
//   The next item is taken at the result edge; the chain walk sets the rate.
// Reset: all buckets empty, free list empty, pool unused, bucket count 10.
//   No clearing pass; the first item may start right after reset.
// ----------------------------------------------------------------------------
module chained_hash_table #(
    parameter int NUM_BUCKETS = 16,
    parameter int POOL_NODES  = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cht_pkg::FUNC_W-1:0]          func,
    input  logic [cht_pkg::KEY_W-1:0]           key,
    input  logic signed [cht_pkg::VALUE_W-1:0]  value,
    output logic                                done,
    output logic [cht_pkg::STATUS_W-1:0]        status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cht_pkg::CFG_W-1:0]           cfg_data
);
    import cht_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    // config register always ready
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    cht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    cht_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .func     (func),
        .key      (key),
        .value    (VALUE_W'(value)),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> dv/chained_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_tb
// Self-checking bench for the chained hash table. A table of directed items
// covers empty buckets, unknown operations, duplicates and free-list reuse.
// Random phases then run at several bucket counts, one of them long enough
// to exhaust the node pool. Each status is checked against a row's typed code
// or a shadow copy of the buckets, node pool and free list kept in the bench.
// ----------------------------------------------------------------------------
module chained_hash_table_tb;

    import cht_pkg::*;

    localparam int NUM_BUCKETS     = 16;
    localparam int POOL_NODES      = 256;
    localparam int CLK_PERIOD      = 12;
    localparam longint WATCHDOG_CYCLES = 4_000_000;
    localparam int MAX_PRINTED     = 50;

    // end-of-chain / empty pool marker
    localparam logic [8:0] NIL = 9'(POOL_NODES);

    // operation code with no defined meaning
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [FUNC_W-1:0]          func;
    logic [KEY_W-1:0]           key;
    logic signed [VALUE_W-1:0]  value;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_data;

    // one outstanding item and the status it should produce
    typedef struct packed {
        logic [FUNC_W-1:0]   fn;
        logic [KEY_W-1:0]    k;
        logic [VALUE_W-1:0]  v;
        logic [STATUS_W-1:0] st;
    } status_exp_t;

    // directed item; st is only used where typed is set
    typedef struct packed {
        logic [FUNC_W-1:0]   fn;
        logic [KEY_W-1:0]    k;
        logic [VALUE_W-1:0]  v;
        logic                typed;
        logic [STATUS_W-1:0] st;
    } dir_row_t;

    status_exp_t pending_status [$];
    status_exp_t seen_exp;
    int          mismatch_cnt = 0;
    int          burst_left   = 0;

    // shadow hash table
    logic [8:0]         tbl_head [NUM_BUCKETS];
    logic [31:0]        tbl_val  [POOL_NODES];
    logic [8:0]         tbl_link [POOL_NODES];
    logic [8:0]         next_fresh;
    logic [8:0]         free_top;
    logic [CFG_W-1:0]   tbl_bucket_count;

    dir_row_t directed_rows [22] = '{
        // empty table
        '{FN_SEARCH, 31'd0,          32'h0000_0000, 1'b1, ST_NOT_FOUND},
        '{FN_REMOVE, 31'h7FFF_FFFF,  32'h8000_0000, 1'b1, ST_NOT_FOUND},
        '{FN_UNUSED, 31'd5,          32'h0000_0001, 1'b1, ST_NOT_FOUND},
        // fill buckets 0 and 7, duplicate value in bucket 0
        '{FN_INSERT, 31'd0,          32'h0000_0000, 1'b1, ST_INSERTED},
        '{FN_INSERT, 31'h7FFF_FFFF,  32'h7FFF_FFFF, 1'b1, ST_INSERTED},
        '{FN_INSERT, 31'h7FFF_FFFF,  32'h8000_0000, 1'b1, ST_INSERTED},
        '{FN_INSERT, 31'd10,         32'h0000_0000, 1'b1, ST_INSERTED},
        '{FN_SEARCH, 31'd20,         32'h0000_0000, 1'b0, ST_FOUND},
        '{FN_SEARCH, 31'd17,         32'h7FFF_FFFF, 1'b0, ST_FOUND},
        '{FN_SEARCH, 31'd7,          32'hFFFF_FFFF, 1'b0, ST_NOT_FOUND},
        // duplicates leave one at a time
        '{FN_REMOVE, 31'd0,          32'h0000_0000, 1'b0, ST_REMOVED},
        '{FN_SEARCH, 31'd0,          32'h0000_0000, 1'b0, ST_FOUND},
        '{FN_REMOVE, 31'd30,         32'h0000_0000, 1'b0, ST_REMOVED},
        '{FN_REMOVE, 31'd0,          32'h0000_0000, 1'b0, ST_NOT_FOUND},
        // nodes come back off the free list
        '{FN_INSERT, 31'd3,          32'hFFFF_FFFF, 1'b1, ST_INSERTED},
        '{FN_INSERT, 31'd13,         32'h0000_0001, 1'b1, ST_INSERTED},
        '{FN_INSERT, 31'd3,          32'h0000_0002, 1'b1, ST_INSERTED},
        // unlink from tail and middle of a chain
        '{FN_REMOVE, 31'd23,         32'h0000_0001, 1'b0, ST_REMOVED},
        '{FN_REMOVE, 31'd3,          32'hFFFF_FFFF, 1'b0, ST_REMOVED},
        '{FN_SEARCH, 31'd3,          32'h0000_0002, 1'b0, ST_FOUND},
        '{FN_UNUSED, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND},
        '{FN_INSERT, 31'd9,          32'h5A5A_5A5A, 1'b1, ST_INSERTED}
    };

    chained_hash_table #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .key       (key),
        .value     (value),
        .done      (done),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
    begin
        mismatch_cnt++;
        // keep the log short if the design is badly broken
        if (mismatch_cnt <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
    end
    endtask

    // bucket count as the block uses it: zero is one, saturates at the top
    function automatic int unsigned eff_buckets();
        if (tbl_bucket_count == '0)
            return 1;
        if (tbl_bucket_count > NUM_BUCKETS)
            return NUM_BUCKETS;
        return tbl_bucket_count;
    endfunction

    // apply one item to the shadow table, return its status
    function automatic logic [STATUS_W-1:0] predict_status(
        input logic [FUNC_W-1:0]  fn,
        input logic [KEY_W-1:0]   k,
        input logic [VALUE_W-1:0] v
    );
        int unsigned         b;
        int                  steps;
        logic [8:0]          nd;
        logic [8:0]          cur;
        logic [8:0]          prev;
        logic [STATUS_W-1:0] st;
        b  = k % eff_buckets();
        st = ST_NOT_FOUND;
        nd = NIL;
        if (fn == FN_INSERT)
        begin
            // free list first, then a never-used node
            if (free_top < NIL)
            begin
                nd       = free_top;
                free_top = tbl_link[nd];
                st       = ST_INSERTED;
            end
            else if (next_fresh < NIL)
            begin
                nd         = next_fresh;
                next_fresh = next_fresh + 9'd1;
                st         = ST_INSERTED;
            end
            else
                st = ST_FULL;
            if (st == ST_INSERTED)
            begin
                tbl_val[nd]  = v;
                tbl_link[nd] = tbl_head[b];
                tbl_head[b]  = nd;
            end
        end
        else if (fn == FN_SEARCH || fn == FN_REMOVE)
        begin
            cur  = tbl_head[b];
            prev = NIL;
            for (steps = 0; steps < POOL_NODES && cur < NIL && st == ST_NOT_FOUND; steps++)
            begin
                if (tbl_val[cur] == v)
                begin
                    st = ST_FOUND;
                    if (fn == FN_REMOVE)
                    begin
                        if (prev >= NIL)
                            tbl_head[b] = tbl_link[cur];
                        else
                            tbl_link[prev] = tbl_link[cur];
                        tbl_link[cur] = free_top;
                        free_top      = cur;
                        st            = ST_REMOVED;
                    end
                end
                else
                begin
                    prev = cur;
                    cur  = tbl_link[cur];
                end
            end
        end
        return st;
    endfunction

    // pick a stored value somewhere along a live chain, and a key that maps there
    function automatic bit pick_stored(inout logic [KEY_W-1:0] k, inout logic [VALUE_W-1:0] v);
        int unsigned n;
        int unsigned b0;
        int unsigned b;
        int unsigned i;
        int          len;
        int          steps;
        logic [8:0]  cur;
        n  = eff_buckets();
        b0 = $urandom_range(0, n - 1);
        b  = b0;
        for (i = 0; i < n; i++)
        begin
            b = (b0 + i) % n;
            if (tbl_head[b] < NIL)
                break;
        end
        if (i == n)
            return 1'b0;
        len = 0;
        cur = tbl_head[b];
        while (cur < NIL && len < POOL_NODES)
        begin
            len++;
            cur = tbl_link[cur];
        end
        steps = $urandom_range(0, len - 1);
        cur   = tbl_head[b];
        repeat (steps) cur = tbl_link[cur];
        v = tbl_val[cur];
        k = KEY_W'(b + n * $urandom_range(0, (32'h7FFF_FFFF - b) / n));
        return 1'b1;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 2))
            0:       return KEY_W'($urandom);
            1:       return KEY_W'($urandom_range(0, 40));
            default: return 31'h7FFF_FFFF - KEY_W'($urandom_range(0, 40));
        endcase
    endfunction

    // small values give duplicates and hits, wide ones toggle every bit
    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0, 1:    return VALUE_W'(int'($urandom_range(0, 15)) - 8);
            2:       return $urandom;
            default:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
        endcase
    endfunction

    // present one item, wait for it to be taken, then maybe idle
    task automatic send_item(
        input logic [FUNC_W-1:0]   fn,
        input logic [KEY_W-1:0]    k,
        input logic [VALUE_W-1:0]  v,
        input logic                typed,
        input logic [STATUS_W-1:0] typed_st
    );
        status_exp_t         e;
        logic [STATUS_W-1:0] model_st;
        int                  gap;
    begin
        start <= 1'b1;
        func  <= fn;
        key   <= k;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        model_st = predict_status(fn, k, v);
        e.fn = fn;
        e.k  = k;
        e.v  = v;
        e.st = typed ? typed_st : model_st;
        pending_status.push_back(e);

        // bursts of back-to-back items with random gaps in between
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 25);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    end
    endtask

    // hold off until every outstanding item has returned its status
    task automatic wait_drained();
    begin
        start <= 1'b0;
        while (pending_status.size() != 0 || busy)
            @(posedge clk);
    end
    endtask

    task automatic write_bucket_count(input logic [CFG_W-1:0] bc);
    begin
        cfg_valid <= 1'b1;
        cfg_data  <= bc;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid        <= 1'b0;
        tbl_bucket_count  = bc;
    end
    endtask

    // one random phase at a given bucket count and operation mix (percent)
    task automatic run_phase(
        input logic [CFG_W-1:0] bc,
        input int               n_items,
        input int               w_ins,
        input int               w_srch,
        input int               w_rem
    );
        int                 r;
        logic [FUNC_W-1:0]  fn;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
    begin
        wait_drained();
        write_bucket_count(bc);
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < w_ins)
                fn = FN_INSERT;
            else if (r < w_ins + w_srch)
                fn = FN_SEARCH;
            else if (r < w_ins + w_srch + w_rem)
                fn = FN_REMOVE;
            else
                fn = FN_UNUSED;
            k = rand_key();
            v = rand_value();
            // mostly aim lookups at something that is really there
            if ((fn == FN_SEARCH || fn == FN_REMOVE) && $urandom_range(0, 99) < 70)
                void'(pick_stored(k, v));
            send_item(fn, k, v, 1'b0, ST_NOT_FOUND);
        end
    end
    endtask

    // result checker: done is a one-cycle strobe, no back-pressure
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_status.size() == 0)
                report_mismatch($sformatf("status %0d with no item outstanding", status));
            else
            begin
                seen_exp = pending_status.pop_front();
                if (status !== seen_exp.st)
                    report_mismatch($sformatf(
                        "func %0d key 0x%08h value 0x%08h: status %0d, expected %0d",
                        seen_exp.fn, seen_exp.k, seen_exp.v, status, seen_exp.st));
            end
        end
    end

    // main sequence
    initial
    begin
        int i;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= FN_INSERT;
        key       <= '0;
        value     <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;

        for (i = 0; i < NUM_BUCKETS; i++)
            tbl_head[i] = NIL;
        for (i = 0; i < POOL_NODES; i++)
        begin
            tbl_val[i]  = '0;
            tbl_link[i] = '0;
        end
        next_fresh       = '0;
        free_top         = NIL;
        tbl_bucket_count = CFG_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at the reset bucket count
        foreach (directed_rows[j])
            send_item(directed_rows[j].fn, directed_rows[j].k, directed_rows[j].v,
                      directed_rows[j].typed, directed_rows[j].st);

        // single bucket, then zero (also one bucket)
        run_phase(5'd1, 150, 40, 30, 25);
        run_phase(5'd0, 100, 40, 30, 25);
        // insert-heavy at full width until the pool runs dry
        run_phase(5'd16, 400, 80, 10, 8);
        // count above the top saturates; drain the pool again
        run_phase(5'd31, 300, 15, 25, 55);
        run_phase(5'd7, 300, 35, 30, 30);
        repeat (4)
            run_phase(CFG_W'($urandom_range(1, NUM_BUCKETS)), 100, 35, 30, 30);

        wait_drained();
        // room for any stray result to show up
        repeat (40) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
